/* design/assert_macros.svh */
// assertion macros shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/exptok_pkg.sv */
// types, constants and byte classification for the expression tokenizer
`timescale 1ns / 1ps

package exptok_pkg;

  // widths fixed by the word formats
  localparam int unsigned SpanW    = 16;
  localparam int unsigned MaxRes   = 5;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxW  = $clog2(MaxRes);

  // group queue between front and back
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // characters with special handling
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharAmp    = 8'h26;
  localparam logic [7:0] CharBar    = 8'h7C;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCaret  = 8'h5E;

  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_NUMBER   = 5'd1,
    TK_IDENT    = 5'd2,
    TK_DOLLAR   = 5'd3,
    TK_PLUS     = 5'd4,
    TK_MINUS    = 5'd5,
    TK_STAR     = 5'd6,
    TK_SLASH    = 5'd7,
    TK_CARET    = 5'd8,
    TK_QUESTION = 5'd9,
    TK_COLON    = 5'd10,
    TK_LPAREN   = 5'd11,
    TK_RPAREN   = 5'd12,
    TK_COMMA    = 5'd13,
    TK_LT       = 5'd14,
    TK_LE       = 5'd15,
    TK_GT       = 5'd16,
    TK_GE       = 5'd17,
    TK_ASSIGN   = 5'd18,
    TK_EQ       = 5'd19,
    TK_BANG     = 5'd20,
    TK_NE       = 5'd21,
    TK_AND      = 5'd22,
    TK_OR       = 5'd23,
    TK_DOT      = 5'd24
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BYTE = 2'd1,
    ERR_LONG = 2'd2
  } err_e;

  // operator waiting for a possible second character
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LT     = 3'd1,
    OP_GT     = 3'd2,
    OP_ASSIGN = 3'd3,
    OP_BANG   = 3'd4,
    OP_AMP    = 3'd5,
    OP_BAR    = 3'd6
  } pend_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
  } tok_in_t;

  typedef struct packed {
    tok_kind_e        token_kind;
    logic [SpanW-1:0] span_start;
    logic [SpanW-1:0] span_stop;
    err_e             error_code;
    logic             final_result;
    logic             run_last;
  } tok_out_t;

  // one result inside a group
  typedef struct packed {
    tok_kind_e        kind;
    logic [SpanW-1:0] start;
    logic [SpanW-1:0] stop;
    err_e             err;
    logic             fin;
  } res_t;

  // all results caused by one input word
  typedef struct packed {
    logic [ResCntW-1:0]     count;
    res_t [MaxRes-1:0]      slot;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_dec_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return c inside {"e", "E"};
  endfunction

  // single-character operators, TK_END when the byte is none of them
  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      CharDollar: k = TK_DOLLAR;
      "+":        k = TK_PLUS;
      "-":        k = TK_MINUS;
      "*":        k = TK_STAR;
      "/":        k = TK_SLASH;
      CharCaret:  k = TK_CARET;
      "?":        k = TK_QUESTION;
      ":":        k = TK_COLON;
      "(":        k = TK_LPAREN;
      ")":        k = TK_RPAREN;
      ",":        k = TK_COMMA;
      CharDot:    k = TK_DOT;
      default:    k = TK_END;
    endcase
    return k;
  endfunction

  // operator starters that may pair with a following byte
  function automatic pend_e pending_code(input logic [7:0] c);
    pend_e p;
    case (c)
      "<":     p = OP_LT;
      ">":     p = OP_GT;
      CharEq:  p = OP_ASSIGN;
      "!":     p = OP_BANG;
      CharAmp: p = OP_AMP;
      CharBar: p = OP_BAR;
      default: p = OP_NONE;
    endcase
    return p;
  endfunction

  // pending operator that stands on its own
  function automatic logic op_is_single(input pend_e p);
    return p inside {OP_LT, OP_GT, OP_ASSIGN, OP_BANG};
  endfunction

  function automatic tok_kind_e op_single_kind(input pend_e p);
    tok_kind_e k;
    case (p)
      OP_LT:     k = TK_LT;
      OP_GT:     k = TK_GT;
      OP_ASSIGN: k = TK_ASSIGN;
      OP_BANG:   k = TK_BANG;
      default:   k = TK_END;
    endcase
    return k;
  endfunction

  function automatic logic op_pairs(input pend_e p, input logic [7:0] c);
    return (op_is_single(p) && c == CharEq) ||
           (p == OP_AMP && c == CharAmp) || (p == OP_BAR && c == CharBar);
  endfunction

  function automatic tok_kind_e op_pair_kind(input pend_e p);
    tok_kind_e k;
    case (p)
      OP_LT:     k = TK_LE;
      OP_GT:     k = TK_GE;
      OP_ASSIGN: k = TK_EQ;
      OP_BANG:   k = TK_NE;
      OP_AMP:    k = TK_AND;
      OP_BAR:    k = TK_OR;
      default:   k = TK_END;
    endcase
    return k;
  endfunction

endpackage

/* design/expression_tokenizer.sv */
// A text word's results are queued at its accept edge and show once the groups ahead have left.
// Throughput: one text word per cycle while the four-group queue between front and back has room.
// Results leave one per cycle while out_ready_i is high, so a word causing n results gives n output words.
// Reset: rst_ni asynchronous active low; clears scanner state, queue pointers and slot index.
// No clearing pass: the block is ready for words as soon as reset is released.
`timescale 1ns / 1ps

module expression_tokenizer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  exptok_pkg::tok_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output exptok_pkg::tok_out_t out_data_o
);
  import exptok_pkg::*;

  logic    push;
  logic    pop;
  group_t  group_in;
  group_t  group_out;
  q_stat_t stat;

  // scanner front
  exptok_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .stat_i     (stat),
    .push_o     (push),
    .group_o    (group_in)
  );

  // group queue
  exptok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .group_i (group_in),
    .pop_i   (pop),
    .group_o (group_out),
    .stat_o  (stat)
  );

  // result back end
  exptok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .group_i     (group_out),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/exptok_queue.sv */
// group queue between the scanner front and the result back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exptok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  exptok_pkg::group_t  group_i,
  input  logic                pop_i,
  output exptok_pkg::group_t  group_o,
  output exptok_pkg::q_stat_t stat_o
);
  import exptok_pkg::*;

  group_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d;
  logic [QPtrW-1:0]   rptr_q, rptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (count_q == QCntW'(QDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign group_o      = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= group_i;
    end
  end

  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= QCntW'(QDepth), "queue overfilled")

endmodule

/* design/exptok_front.sv */
// scanner front: accepts text words, tracks token state, builds result groups
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exptok_front #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  exptok_pkg::tok_in_t in_data_i,
  input  exptok_pkg::q_stat_t stat_i,
  output logic                push_o,
  output exptok_pkg::group_t  group_o
);
  import exptok_pkg::*;

  typedef enum logic [9:0] {
    M_IDLE   = 10'b0000000001,
    M_INT    = 10'b0000000010,
    M_FRAC   = 10'b0000000100,
    M_EMARK  = 10'b0000001000,
    M_EPLUS  = 10'b0000010000,
    M_EMINUS = 10'b0000100000,
    M_EDIG   = 10'b0001000000,
    M_IDENT  = 10'b0010000000,
    M_OP     = 10'b0100000000,
    M_DROP   = 10'b1000000000
  } mode_e;

  localparam logic [OFFSET_BITS-1:0] OffOne = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OffTwo = OFFSET_BITS'(2);

  mode_e                  mode_q, mode_d;
  pend_e                  pend_q, pend_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] tb_q, tb_d;
  logic [OFFSET_BITS-1:0] em_q, em_d;

  logic                   in_fire;
  logic                   run_idle;
  logic                   dropped;
  logic [7:0]             c;
  logic [ResCntW-1:0]     cnt;
  res_t [MaxRes-1:0]      slot;
  tok_kind_e              sk;
  pend_e                  pk;

  function automatic res_t mk_res(input tok_kind_e k, input logic [OFFSET_BITS-1:0] s,
                                  input logic [OFFSET_BITS-1:0] e, input err_e er,
                                  input logic f);
    res_t r;
    r.kind  = k;
    r.start = SpanW'(s);
    r.stop  = SpanW'(e);
    r.err   = er;
    r.fin   = f;
    return r;
  endfunction

  assign in_ready_o = !stat_i.full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign c          = in_data_i.text_byte;
  assign sk         = single_kind(c);
  assign pk         = pending_code(c);

  // one byte step, then the end-of-text flush, collected into a group
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    pos_d    = pos_q;
    tb_d     = tb_q;
    em_d     = em_q;
    cnt      = '0;
    slot     = '0;
    run_idle = 1'b0;
    dropped  = 1'b0;

    if (in_fire) begin
      if (in_data_i.has_byte && mode_q != M_DROP) begin
        if (&pos_q) begin
          // offset range used up
          slot[ResIdxW'(cnt)] = mk_res(TK_END, pos_q, pos_q, ERR_LONG, 1'b1);
          cnt    = cnt + 1'b1;
          mode_d = M_DROP;
          pend_d = OP_NONE;
        end else begin
          case (mode_q)
            M_INT, M_FRAC: begin
              if (is_dec_digit(c)) begin
                pos_d = pos_q + OffOne;
              end else if (c == CharDot && mode_q == M_INT) begin
                mode_d = M_FRAC;
                pos_d  = pos_q + OffOne;
              end else if (is_exp(c)) begin
                em_d   = pos_q;
                mode_d = M_EMARK;
                pos_d  = pos_q + OffOne;
              end else begin
                slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_q, pos_q, ERR_NONE, 1'b0);
                cnt      = cnt + 1'b1;
                run_idle = 1'b1;
              end
            end
            M_EMARK: begin
              if (is_dec_digit(c)) begin
                mode_d = M_EDIG;
                pos_d  = pos_q + OffOne;
              end else if (c == "+") begin
                mode_d = M_EPLUS;
                pos_d  = pos_q + OffOne;
              end else if (c == "-") begin
                mode_d = M_EMINUS;
                pos_d  = pos_q + OffOne;
              end else begin
                // no exponent: the e starts an identifier
                slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_q, em_q, ERR_NONE, 1'b0);
                cnt  = cnt + 1'b1;
                tb_d = em_q;
                if (is_alpha(c) || is_dec_digit(c)) begin
                  mode_d = M_IDENT;
                  pos_d  = pos_q + OffOne;
                end else begin
                  slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, em_q, pos_q, ERR_NONE, 1'b0);
                  cnt      = cnt + 1'b1;
                  run_idle = 1'b1;
                end
              end
            end
            M_EPLUS, M_EMINUS: begin
              if (is_dec_digit(c)) begin
                mode_d = M_EDIG;
                pos_d  = pos_q + OffOne;
              end else begin
                // back out of the signed exponent
                slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_q, em_q, ERR_NONE, 1'b0);
                cnt = cnt + 1'b1;
                slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, em_q, em_q + OffOne, ERR_NONE, 1'b0);
                cnt = cnt + 1'b1;
                slot[ResIdxW'(cnt)] = mk_res((mode_q == M_EPLUS) ? TK_PLUS : TK_MINUS,
                                             em_q + OffOne, em_q + OffTwo, ERR_NONE, 1'b0);
                cnt      = cnt + 1'b1;
                run_idle = 1'b1;
              end
            end
            M_EDIG: begin
              if (is_dec_digit(c)) begin
                pos_d = pos_q + OffOne;
              end else begin
                slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_q, pos_q, ERR_NONE, 1'b0);
                cnt      = cnt + 1'b1;
                run_idle = 1'b1;
              end
            end
            M_IDENT: begin
              if (is_alpha(c) || is_dec_digit(c)) begin
                pos_d = pos_q + OffOne;
              end else begin
                slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, tb_q, pos_q, ERR_NONE, 1'b0);
                cnt      = cnt + 1'b1;
                run_idle = 1'b1;
              end
            end
            M_OP: begin
              pend_d = OP_NONE;
              if (op_pairs(pend_q, c)) begin
                slot[ResIdxW'(cnt)] = mk_res(op_pair_kind(pend_q), tb_q, pos_q + OffOne,
                                             ERR_NONE, 1'b0);
                cnt    = cnt + 1'b1;
                mode_d = M_IDLE;
                pos_d  = pos_q + OffOne;
              end else if (op_is_single(pend_q)) begin
                slot[ResIdxW'(cnt)] = mk_res(op_single_kind(pend_q), tb_q, tb_q + OffOne,
                                             ERR_NONE, 1'b0);
                cnt      = cnt + 1'b1;
                run_idle = 1'b1;
              end else begin
                // lone & or |
                slot[ResIdxW'(cnt)] = mk_res(TK_END, tb_q, tb_q + OffOne, ERR_BYTE, 1'b1);
                cnt    = cnt + 1'b1;
                mode_d = M_DROP;
              end
            end
            default: begin
              run_idle = 1'b1;
            end
          endcase

          // byte seen from the idle state
          if (run_idle) begin
            mode_d = M_IDLE;
            if (is_space(c)) begin
              pos_d = pos_q + OffOne;
            end else if (is_dec_digit(c)) begin
              tb_d   = pos_q;
              mode_d = M_INT;
              pos_d  = pos_q + OffOne;
            end else if (is_alpha(c)) begin
              tb_d   = pos_q;
              mode_d = M_IDENT;
              pos_d  = pos_q + OffOne;
            end else if (pk != OP_NONE) begin
              tb_d   = pos_q;
              pend_d = pk;
              mode_d = M_OP;
              pos_d  = pos_q + OffOne;
            end else if (sk != TK_END) begin
              slot[ResIdxW'(cnt)] = mk_res(sk, pos_q, pos_q + OffOne, ERR_NONE, 1'b0);
              cnt   = cnt + 1'b1;
              pos_d = pos_q + OffOne;
            end else begin
              slot[ResIdxW'(cnt)] = mk_res(TK_END, pos_q, pos_q + OffOne, ERR_BYTE, 1'b1);
              cnt    = cnt + 1'b1;
              mode_d = M_DROP;
            end
          end
        end
      end

      // end of text: flush the open token, close with End unless the text was dropped, restart
      if (in_data_i.end_of_text) begin
        dropped = (mode_d == M_DROP);
        case (mode_d)
          M_INT, M_FRAC, M_EDIG: begin
            slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_d, pos_d, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_EMARK: begin
            slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_d, em_d, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
            slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, em_d, pos_d, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_EPLUS, M_EMINUS: begin
            slot[ResIdxW'(cnt)] = mk_res(TK_NUMBER, tb_d, em_d, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
            slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, em_d, em_d + OffOne, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
            slot[ResIdxW'(cnt)] = mk_res((mode_d == M_EPLUS) ? TK_PLUS : TK_MINUS,
                                         em_d + OffOne, em_d + OffTwo, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_IDENT: begin
            slot[ResIdxW'(cnt)] = mk_res(TK_IDENT, tb_d, pos_d, ERR_NONE, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_OP: begin
            if (op_is_single(pend_d)) begin
              slot[ResIdxW'(cnt)] = mk_res(op_single_kind(pend_d), tb_d, tb_d + OffOne,
                                           ERR_NONE, 1'b0);
              cnt = cnt + 1'b1;
            end else begin
              slot[ResIdxW'(cnt)] = mk_res(TK_END, tb_d, tb_d + OffOne, ERR_BYTE, 1'b1);
              cnt     = cnt + 1'b1;
              dropped = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (!dropped) begin
          slot[ResIdxW'(cnt)] = mk_res(TK_END, pos_d, pos_d, ERR_NONE, 1'b1);
          cnt = cnt + 1'b1;
        end
        mode_d = M_IDLE;
        pend_d = OP_NONE;
        pos_d  = '0;
        tb_d   = '0;
        em_d   = '0;
      end
    end
  end

  // groups with no result stay out of the queue
  assign push_o        = in_fire && (cnt != '0);
  assign group_o.count = cnt;
  assign group_o.slot  = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= OP_NONE;
      pos_q  <= '0;
      tb_q   <= '0;
      em_q   <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
      em_q   <= em_d;
    end
  end

  `ASSERT_NEXT(a_eot_restarts, clk_i, rst_ni, in_fire && in_data_i.end_of_text, (pos_q == '0) && (mode_q == M_IDLE), "text end did not restart scanner")

endmodule

/* design/exptok_back.sv */
// result back end: walks each queued group and hands out one result per word
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exptok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  exptok_pkg::group_t   group_i,
  input  exptok_pkg::q_stat_t  stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output exptok_pkg::tok_out_t out_data_o
);
  import exptok_pkg::*;

  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               out_fire;
  logic               last;
  res_t               cur;

  assign out_valid_o = !stat_i.empty;
  assign out_fire    = out_valid_o && out_ready_i;
  assign cur         = group_i.slot[idx_q];
  assign last        = ((ResCntW'(idx_q) + 1'b1) == group_i.count);
  assign pop_o       = out_fire && last;

  // result word from the current slot
  assign out_data_o.token_kind   = cur.kind;
  assign out_data_o.span_start   = cur.start;
  assign out_data_o.span_stop    = cur.stop;
  assign out_data_o.error_code   = cur.err;
  assign out_data_o.final_result = cur.fin;
  assign out_data_o.run_last     = last;

  // slot index within the head group
  always_comb begin
    idx_d = idx_q;
    if (out_fire) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `ASSERT_IMPL(a_idx_in_group, clk_i, rst_ni, out_valid_o, ResCntW'(idx_q) < group_i.count, "slot index past group end")

endmodule
